FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
// AIMD_ASSERT:    clocked property, disabled while rst_n is low.
// AIMD_ASSERT_AR: clocked property, also checked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AIMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AIMD_ASSERT_AR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define AIMD_ASSERT_AR(lbl, clk, prop, msg)
`endif

`endif

FILE: src/aimd_pkg.sv
package aimd_pkg;

  // fixed field widths
  localparam int CNT_W         = 32;
  localparam int RATE_PORT_W   = 32;
  localparam int DIV_W         = 8;
  localparam int RATE_BITS_DEF = 32;

  // bit counter is sized from the counter width, which sets the counter compare pass
  localparam int BCNT_W = $clog2(CNT_W);

  // stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;

  // register port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [31:0]      MIN_RATE_RST  = 32'd1;
  localparam logic [31:0]      TARGET_RST    = 32'd1000;
  localparam logic [DIV_W-1:0] DIVISOR_RST   = 8'd2;
  localparam logic [31:0]      STEP_RST      = 32'd100;
  localparam logic [DIV_W-1:0] DIV_ONE       = 8'd1;

  typedef enum logic [1:0] {
    REG_MIN_RATE      = 2'd0,
    REG_TARGET_RATE   = 2'd1,
    REG_BACKOFF_DIV   = 2'd2,
    REG_RECOVERY_STEP = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CNT_FAIL  = 2'd0,
    ST_BASELINE  = 2'd1,
    ST_RATE_FAIL = 2'd2,
    ST_RATE_DONE = 2'd3
  } win_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SEL,
    S_FIN
  } fsm_state_t;

  typedef struct packed {
    logic [31:0]      min_rate;
    logic [31:0]      target_rate;
    logic [DIV_W-1:0] backoff_div;
    logic [31:0]      recovery_step;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture a new window
    logic base_load;  // store counter as baseline
    logic scan;       // counter compare pass
    logic div_en;     // divide / add step inside the scan pass
    logic sel;        // select and compare pass
    logic out_load;   // result goes to the output register
  } ctrl_t;

  typedef struct packed {
    logic ovf;
    logic rate_diff;
  } dp_stat_t;

endpackage

FILE: src/aimd_rate_backoff_controller.sv
// AIMD sample-rate backoff controller.
// Input stream: one transfer per check window. in_tdata carries the cumulative
// overflow counter and the current rate, in_tuser the two read-ok flags.
// Output stream: one transfer per window with the status code, the overflow
// flag, the next rate and the write request. Register port (APB style):
// min_rate @0x0, target_rate @0x4, backoff_div @0x8, recovery_step @0xC.
// Steps from accept to result shown (one window at a time):
//   counter read failed or baseline window: accept, then output load;
//   rate read failed: accept, the bit-serial counter compare pass, output load;
//   rate computed: accept, the counter compare pass followed by a
//   bit-serial select/compare pass of RATE_BITS bits, then output load.
// The divide (one quotient bit per cycle) and the add/clamp run inside the
// counter compare pass, so the 32-bit counter width sets the first pass.
// Reset: registers return to their defaults, no baseline is held and both
// streams go idle. A stalled receiver holds the result in the output
// register; the next window is still accepted and processed, and waits in
// the sequencer until the output register frees up.
`include "assert_macros.svh"

module aimd_rate_backoff_controller import aimd_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] overflow_count, [63:32] current_rate
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] overflow_read_ok, [1] rate_read_ok
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] new_rate
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] window_status, [2] overflowed,
                                             // [3] write_rate
  // register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t        cfg;
  ctrl_t       ctrl;
  dp_stat_t    stat;
  win_status_t status;

  logic [CNT_W-1:0]       count;
  logic [RATE_BITS-1:0]   cur;
  logic [RATE_BITS-1:0]   next_rate;
  logic                   q_bit;
  logic                   q_lsb;
  logic                   out_free;
  logic                   done;
  logic                   ovf_valid;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // field unpack; the rate is taken modulo 2^RATE_BITS
  assign count = in_tdata[CNT_W-1:0];
  assign cur   = in_tdata[CNT_W +: RATE_BITS];

  aimd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  aimd_ctrl #(.RATE_BITS(RATE_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .count_ok (in_tuser[0]),
    .rate_ok  (in_tuser[1]),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl),
    .status   (status)
  );

  aimd_serial_div #(.RATE_BITS(RATE_BITS)) u_div (
    .clk       (clk),
    .load      (ctrl.load),
    .step      (ctrl.div_en),
    .shift_out (ctrl.sel),
    .dividend  (cur),
    .divisor   (cfg.backoff_div),
    .q_bit     (q_bit),
    .q_lsb     (q_lsb)
  );

  aimd_datapath #(.RATE_BITS(RATE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .count     (count),
    .cur       (cur),
    .q_bit     (q_bit),
    .q_lsb     (q_lsb),
    .stat      (stat),
    .next_rate (next_rate)
  );

  // output register: frees when empty or when the current transfer completes
  assign out_free  = !out_tvalid_r || out_tready;
  assign done      = (status == ST_RATE_DONE);
  assign ovf_valid = (status == ST_RATE_FAIL) || (status == ST_RATE_DONE);

  assign out_tdata_nxt = done ? OUT_TDATA_W'(next_rate) : '0;
  assign out_tuser_nxt = {done && stat.rate_diff, ovf_valid && stat.ovf, status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a rate write is only requested on a computed window
  `AIMD_ASSERT(a_write_needs_rate, clk, rst_n, (out_tvalid && out_tuser[3]) |-> (out_tuser[1:0] == ST_RATE_DONE), "write_rate set without a computed rate")
  // overflow is only reported once a baseline exists
  `AIMD_ASSERT(a_ovf_needs_base, clk, rst_n, (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == ST_RATE_FAIL || out_tuser[1:0] == ST_RATE_DONE), "overflowed set on a skipped or baseline window")
  // one window at a time: busy right after an accept
  `AIMD_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "input accepted while a window is in progress")
  // no result is shown in the cycle after reset
  `AIMD_ASSERT_AR(a_reset_idle, clk, $past(!rst_n) |-> !out_tvalid, "result valid right after reset")

endmodule

FILE: src/aimd_cfg_regs.sv
module aimd_cfg_regs import aimd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rate      <= MIN_RATE_RST;
      cfg_r.target_rate   <= TARGET_RST;
      cfg_r.backoff_div   <= DIVISOR_RST;
      cfg_r.recovery_step <= STEP_RST;
    end else if (wr) begin
      unique case (idx)
        REG_MIN_RATE:      cfg_r.min_rate      <= pwdata;
        REG_TARGET_RATE:   cfg_r.target_rate   <= pwdata;
        REG_BACKOFF_DIV:   cfg_r.backoff_div   <= pwdata[DIV_W-1:0];
        REG_RECOVERY_STEP: cfg_r.recovery_step <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_RATE:      prdata = cfg_r.min_rate;
      REG_TARGET_RATE:   prdata = cfg_r.target_rate;
      REG_BACKOFF_DIV:   prdata = CFG_DATA_W'(cfg_r.backoff_div);
      REG_RECOVERY_STEP: prdata = cfg_r.recovery_step;
    endcase
  end

endmodule

FILE: src/aimd_serial_div.sv
// Restoring divider, one quotient bit per step, MSB first.
module aimd_serial_div import aimd_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 step,
  input  logic                 shift_out,
  input  logic [RATE_BITS-1:0] dividend,
  input  logic [DIV_W-1:0]     divisor,
  output logic                 q_bit,
  output logic                 q_lsb
);

  logic [RATE_BITS-1:0] dvd_r;
  logic [RATE_BITS-1:0] quot_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dsr_r;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, dvd_r[RATE_BITS-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};
  assign q_bit = ge;
  assign q_lsb = quot_r[0];

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= (divisor == '0) ? DIV_ONE : divisor;  // zero divides as one
    end else if (step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quot_r <= {quot_r[RATE_BITS-2:0], ge};
    end else if (shift_out) begin
      quot_r <= quot_r >> 1;
    end
  end

endmodule

FILE: src/aimd_datapath.sv
// Bit-serial datapath: counter compare, add/clamp, floor compare, select.
module aimd_datapath import aimd_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  cfg_t                 cfg,
  input  logic [CNT_W-1:0]     count,
  input  logic [RATE_BITS-1:0] cur,
  input  logic                 q_bit,
  input  logic                 q_lsb,
  output dp_stat_t             stat,
  output logic [RATE_BITS-1:0] next_rate
);

  logic [CNT_W-1:0]     last_r;
  logic [CNT_W-1:0]     cnt_sr_r;
  logic [RATE_BITS-1:0] a_sr_r;
  logic [RATE_BITS-1:0] st_sr_r;
  logic [RATE_BITS-1:0] hi_sr_r;
  logic [RATE_BITS-1:0] lo_sr_r;
  logic [RATE_BITS-1:0] sum_sr_r;
  logic [RATE_BITS-1:0] res_sr_r;
  logic                 ne_r;
  logic                 cy_r;
  logic                 lt_r;
  logic                 qdec_r;
  logic                 qgt_r;
  logic                 neq_r;

  logic s_bit;
  logic c_nxt;
  logic sum_lt;
  logic src_bit;

  assign s_bit  = a_sr_r[0] ^ st_sr_r[0] ^ cy_r;
  assign c_nxt  = (a_sr_r[0] & st_sr_r[0]) | (a_sr_r[0] & cy_r) | (st_sr_r[0] & cy_r);
  // carry out means the sum is above any target
  assign sum_lt = lt_r && !cy_r;
  assign src_bit = ne_r ? (qgt_r ? q_lsb : lo_sr_r[0])
                        : (sum_lt ? sum_sr_r[0] : hi_sr_r[0]);

  assign stat.ovf       = ne_r;
  assign stat.rate_diff = neq_r;
  assign next_rate      = res_sr_r;

  // last counter value; shifts in the new count while comparing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctrl.base_load) begin
      last_r <= count;
    end else if (ctrl.scan) begin
      last_r <= {cnt_sr_r[0], last_r[CNT_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cnt_sr_r <= count;
      a_sr_r   <= cur;
      st_sr_r  <= cfg.recovery_step[RATE_BITS-1:0];
      hi_sr_r  <= cfg.target_rate[RATE_BITS-1:0];
      lo_sr_r  <= cfg.min_rate[RATE_BITS-1:0];
      ne_r     <= 1'b0;
      cy_r     <= 1'b0;
      lt_r     <= 1'b0;
      qdec_r   <= 1'b0;
      qgt_r    <= 1'b0;
      neq_r    <= 1'b0;
    end else if (ctrl.scan) begin
      cnt_sr_r <= cnt_sr_r >> 1;
      ne_r     <= ne_r | (cnt_sr_r[0] ^ last_r[0]);
      if (ctrl.div_en) begin
        // sum LSB first, compared against target
        a_sr_r   <= {a_sr_r[0], a_sr_r[RATE_BITS-1:1]};
        st_sr_r  <= st_sr_r >> 1;
        hi_sr_r  <= {hi_sr_r[0], hi_sr_r[RATE_BITS-1:1]};
        sum_sr_r <= {s_bit, sum_sr_r[RATE_BITS-1:1]};
        cy_r     <= c_nxt;
        if (s_bit != hi_sr_r[0]) begin
          lt_r <= hi_sr_r[0];
        end
        // quotient MSB first, compared against floor
        lo_sr_r <= {lo_sr_r[RATE_BITS-2:0], lo_sr_r[RATE_BITS-1]};
        if (!qdec_r && (q_bit != lo_sr_r[RATE_BITS-1])) begin
          qdec_r <= 1'b1;
          qgt_r  <= q_bit;
        end
      end
    end else if (ctrl.sel) begin
      res_sr_r <= {src_bit, res_sr_r[RATE_BITS-1:1]};
      neq_r    <= neq_r | (src_bit ^ a_sr_r[0]);
      a_sr_r   <= {a_sr_r[0], a_sr_r[RATE_BITS-1:1]};
      lo_sr_r  <= {lo_sr_r[0], lo_sr_r[RATE_BITS-1:1]};
      hi_sr_r  <= {hi_sr_r[0], hi_sr_r[RATE_BITS-1:1]};
      sum_sr_r <= {sum_sr_r[0], sum_sr_r[RATE_BITS-1:1]};
    end
  end

endmodule

FILE: src/aimd_ctrl.sv
// Window sequencer: accept, serial passes, result handoff.
module aimd_ctrl import aimd_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        count_ok,
  input  logic        rate_ok,
  input  logic        out_free,
  output logic        in_ready,
  output ctrl_t       ctrl,
  output win_status_t status
);

  fsm_state_t        state_r, state_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  win_status_t       status_r, status_nxt;
  logic              base_vld_r, base_vld_nxt;
  logic              scan_last;
  logic              sel_last;

  assign scan_last = (bcnt_r == BCNT_W'(CNT_W - 1));
  assign sel_last  = (bcnt_r == BCNT_W'(RATE_BITS - 1));
  assign status    = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bcnt_r     <= '0;
      status_r   <= ST_CNT_FAIL;
      base_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bcnt_r     <= bcnt_nxt;
      status_r   <= status_nxt;
      base_vld_r <= base_vld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    bcnt_nxt     = bcnt_r;
    status_nxt   = status_r;
    base_vld_nxt = base_vld_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          bcnt_nxt = '0;
          priority if (!count_ok) begin
            status_nxt = ST_CNT_FAIL;
            state_nxt  = S_FIN;
          end else if (!base_vld_r) begin
            status_nxt   = ST_BASELINE;
            base_vld_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            status_nxt = rate_ok ? ST_RATE_DONE : ST_RATE_FAIL;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          bcnt_nxt  = '0;
          state_nxt = (status_r == ST_RATE_DONE) ? S_SEL : S_FIN;
        end else begin
          bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      S_SEL: begin
        if (sel_last) begin
          bcnt_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        ctrl.load      = in_valid;
        ctrl.base_load = in_valid && count_ok && !base_vld_r;
      end
      S_SCAN: begin
        ctrl.scan   = 1'b1;
        ctrl.div_en = {1'b0, bcnt_r} < (BCNT_W + 1)'(RATE_BITS);
      end
      S_SEL: begin
        ctrl.sel = 1'b1;
      end
      S_FIN: begin
        ctrl.out_load = out_free;
      end
    endcase
  end

endmodule

FILE: tb/sv/aimd_checker.sv
`timescale 1ns / 100ps

module aimd_checker import aimd_pkg::*; #(
  parameter int RATE_BITS = RATE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] overflow_count, [63:32] current_rate
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] overflow_read_ok, [1] rate_read_ok
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] new_rate
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] window_status, [2] overflowed,
                                             // [3] write_rate
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic                   cfg_pready,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output int unsigned            mismatches,
  output int unsigned            results_owed
);

  localparam logic [31:0] RATE_MASK = (RATE_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << RATE_BITS) - 64'd1);

  typedef struct packed {
    win_status_t status;
    logic        ovf;
    logic [31:0] new_rate;
    logic        write_rate;
  } window_result_t;

  // shadow registers and controller state
  logic [31:0]      floor_rate;
  logic [31:0]      ceil_rate;
  logic [DIV_W-1:0] divisor;
  logic [31:0]      step_hz;
  logic [31:0]      held_count;
  logic             have_baseline;

  window_result_t expected_results[$];

  // next-rate decision for one window; updates the held counter and baseline
  function automatic window_result_t judge_window(input logic [31:0] count,
                                                  input logic count_ok,
                                                  input logic [31:0] rate,
                                                  input logic rate_ok);
    window_result_t   r;
    logic             ovf;
    logic [31:0]      cur;
    logic [31:0]      quot;
    logic [31:0]      lo;
    logic [31:0]      nxt;
    logic [32:0]      sum;
    logic [32:0]      hi;
    logic [DIV_W-1:0] d;
    r = '0;
    r.status = ST_CNT_FAIL;
    if (!count_ok) return r;
    if (!have_baseline) begin
      held_count    = count;
      have_baseline = 1'b1;
      r.status      = ST_BASELINE;
      return r;
    end
    ovf        = (count != held_count);
    held_count = count;
    r.ovf      = ovf;
    if (!rate_ok) begin
      r.status = ST_RATE_FAIL;
      return r;
    end
    cur = rate & RATE_MASK;
    if (ovf) begin
      d    = (divisor == '0) ? DIV_ONE : divisor;
      quot = cur / {{(32-DIV_W){1'b0}}, d};
      lo   = floor_rate & RATE_MASK;
      nxt  = (quot > lo) ? quot : lo;
    end else begin
      // one bit wider so a large step never wraps
      sum = {1'b0, cur} + {1'b0, step_hz & RATE_MASK};
      hi  = {1'b0, ceil_rate & RATE_MASK};
      nxt = (sum < hi) ? sum[31:0] : hi[31:0];
    end
    r.status     = ST_RATE_DONE;
    r.new_rate   = nxt;
    r.write_rate = (nxt != cur);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    window_result_t want;
    int unsigned    errs;
    errs = 0;
    if (!rst_n) begin
      floor_rate    = MIN_RATE_RST;
      ceil_rate     = TARGET_RST;
      divisor       = DIVISOR_RST;
      step_hz       = STEP_RST;
      held_count    = '0;
      have_baseline = 1'b0;
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_MIN_RATE:      floor_rate = cfg_pwdata;
          REG_TARGET_RATE:   ceil_rate  = cfg_pwdata;
          REG_BACKOFF_DIV:   divisor    = cfg_pwdata[DIV_W-1:0];
          REG_RECOVERY_STEP: step_hz    = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(judge_window(in_tdata[31:0], in_tuser[0],
                                                in_tdata[63:32], in_tuser[1]));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser[1:0] !== want.status) begin
            $display("%0t: window_status expected %0d, got %0d",
                     $time, want.status, out_tuser[1:0]);
            errs++;
          end
          if (out_tuser[2] !== want.ovf) begin
            $display("%0t: overflowed expected %0d, got %0d", $time, want.ovf, out_tuser[2]);
            errs++;
          end
          if (out_tdata[31:0] !== want.new_rate) begin
            $display("%0t: new_rate expected %h, got %h", $time, want.new_rate, out_tdata[31:0]);
            errs++;
          end
          if (out_tuser[3] !== want.write_rate) begin
            $display("%0t: write_rate expected %0d, got %0d",
                     $time, want.write_rate, out_tuser[3]);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
    results_owed <= expected_results.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Top: clock, reset, stimulus and verdict. All prediction and comparison
// lives in aimd_checker, which watches the same wires as the DUT.
module testbench;
  import aimd_pkg::*;

  localparam int IDLE_PCT          = 18;    // idle share per side, percent
  localparam int WATCHDOG_LIMIT    = 3000;  // cycles with no transfer at all
  localparam int HOLD_CYCLES       = 400;   // long receiver hold-off
  localparam int PHASES            = 8;
  localparam int WINDOWS_PER_PHASE = 250;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // [31:0] overflow_count, [63:32] current_rate
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;   // [0] overflow_read_ok, [1] rate_read_ok
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [31:0] new_rate
  logic [OUT_TUSER_W-1:0] out_tuser;          // [1:0] window_status, [2] overflowed,
                                              // [3] write_rate
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int unsigned mismatches;
  int unsigned results_owed;

  // stimulus-side bookkeeping
  bit          steady          = 1'b0;  // both sides stop idling while set
  int unsigned hold_off_cycles = 0;     // set by stimulus, consumed by the receiver
  int unsigned windows_sent    = 0;
  int unsigned settings_used   = 0;
  logic [31:0] last_count      = '0;    // last counter value actually read ok
  logic [31:0] shadow_min      = MIN_RATE_RST;
  logic [31:0] shadow_target   = TARGET_RST;
  logic [31:0] shadow_step     = STEP_RST;

  aimd_rate_backoff_controller DUT (.*);

  aimd_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random back-pressure, none while steady. A hold-off request
  // parks tready low for the whole stretch so the block backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_tready <= 1'b0;
        while (hold_off_cycles != 0) begin
          @(posedge clk);
          hold_off_cycles--;
        end
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results still owed",
             $time, WATCHDOG_LIMIT, results_owed);
    $display("FAIL");
    $finish;
  end

  // One check window. tvalid stays high after the transfer, so back-to-back
  // windows never see it dropped and raised in the same step.
  task automatic send_window(input logic [31:0] cnt, input logic cnt_ok,
                             input logic [31:0] rate, input logic rate_ok);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rate, cnt};
    in_tuser  <= {rate_ok, cnt_ok};
    do @(posedge clk); while (!in_tready);
    if (cnt_ok) last_count = cnt;
    windows_sent++;
  endtask

  // Stop offering and wait for every outstanding result. The first edge
  // lets the checker's owed count catch up with the last transfer.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Setup then access phase; the write lands on the access edge.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Reprogram all four registers with the block idle. Divisor upper bits
  // carry junk, which the register must drop.
  task automatic apply_setting(input logic [31:0] floor_hz, input logic [31:0] ceil_hz,
                               input logic [7:0] div, input logic [31:0] step);
    wait_drained();
    write_reg(REG_MIN_RATE, floor_hz);
    write_reg(REG_TARGET_RATE, ceil_hz);
    write_reg(REG_BACKOFF_DIV, {24'($urandom), div});
    write_reg(REG_RECOVERY_STEP, step);
    shadow_min    = floor_hz;
    shadow_target = ceil_hz;
    shadow_step   = step;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_divisor();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(2, 16));
    endcase
  endfunction

  // Rates cluster around the floor and the target so clamps actually fire.
  function automatic logic [31:0] pick_rate();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return shadow_target - 32'($urandom_range(3)) * shadow_step;
      3:       return shadow_min + 32'($urandom_range(3));
      4:       return shadow_target;
      5:       return $urandom_range(5000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed windows: counter either held or bumped, reads rarely
  // fail. A small share is pure noise.
  task automatic send_random_window();
    logic [31:0] cnt;
    logic        cnt_ok;
    logic        rate_ok;
    if ($urandom_range(99) < 8) begin
      send_window($urandom, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
      return;
    end
    cnt_ok  = ($urandom_range(99) >= 4);
    rate_ok = ($urandom_range(99) >= 8);
    case ($urandom_range(9))
      6, 7:    cnt = last_count + 32'd1;
      8:       cnt = $urandom;
      9:       cnt = last_count + 32'($urandom_range(2, 1000));
      default: cnt = last_count;
    endcase
    send_window(cnt, cnt_ok, pick_rate(), rate_ok);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset defaults: floor 1, target 1000, divisor 2, step 100
    send_window(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1);  // counter read fails, no baseline
    send_window(32'd0, 1'b1, 32'd0, 1'b0);                  // baseline taken
    send_window(32'd0, 1'b1, 32'd0, 1'b0);                  // rate read fails, clean
    send_window(32'd5, 1'b1, 32'd0, 1'b0);                  // rate read fails, overflow seen
    send_window(32'd5, 1'b1, 32'd500, 1'b1);                // additive step
    send_window(32'd5, 1'b1, 32'd1000, 1'b1);               // already at target, no write
    send_window(32'd5, 1'b1, 32'd950, 1'b1);                // step clamped to target
    send_window(32'd6, 1'b1, 32'd1000, 1'b1);               // halve
    send_window(32'd7, 1'b1, 32'd1, 1'b1);                  // quotient under floor
    send_window(32'd12345, 1'b0, 32'd7, 1'b1);              // failed read leaves state alone
    send_window(32'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);          // huge rate clamped on recovery
    send_window(32'd0, 1'b1, 32'd0, 1'b1);                  // floor above current rate

    // --- max floor/target/step, divisor zero acts as one
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
    send_window(32'd1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_window(32'd1, 1'b1, 32'h8000_0000, 1'b1);          // wide sum, no wrap
    send_window(32'd2, 1'b1, 32'd5, 1'b1);

    // --- everything zero, largest divisor
    apply_setting(32'd0, 32'd0, 8'd255, 32'd0);
    send_window(32'd3, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_window(32'd3, 1'b1, 32'd12345, 1'b1);              // clamp down to zero target
    send_window(32'd3, 1'b1, 32'd0, 1'b1);

    // --- floor above target wins on backoff
    apply_setting(32'h8000_0000, 32'd10, 8'd1, 32'd1);
    send_window(32'd4, 1'b1, 32'd20, 1'b1);
    send_window(32'd4, 1'b1, 32'd20, 1'b1);

    // --- random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        apply_setting(32'd100, 32'd48000, 8'd2, 32'd1000);
      else
        apply_setting(pick_reg_value(), pick_reg_value(), pick_divisor(), pick_reg_value());
      steady = (p == 2);
      if (p == 4) hold_off_cycles = HOLD_CYCLES;  // block fills, input stalls
      for (int i = 0; i < WINDOWS_PER_PHASE; i++) begin
        if (p == 5 && i == WINDOWS_PER_PHASE / 2) wait_drained();
        send_random_window();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (100) @(posedge clk);

    $display("Ran %0d check windows over %0d register settings plus reset defaults,",
             windows_sent, settings_used);
    $display("with read failures, counter jumps, clamps and a %0d-cycle result hold.",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
